// ===== sv/rpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_pkg: shared definitions for the RSSI proximity flasher
// Panel color words, state limits, configuration register indexes and widths.
// ----------------------------------------------------------------------------
package rpf_pkg;

	// Panel color words in the panel's inverted BGR565 format.
	localparam logic [15:0] COLOR_RED   = 16'hFFE0;
	localparam logic [15:0] COLOR_BLACK = 16'hFFFF;
	localparam logic [15:0] COLOR_IDLE  = 16'hFEBF;

	localparam int unsigned  AGE_W      = 17;
	localparam logic [16:0]  AGE_MAX    = 17'h1FFFF;
	localparam logic signed [7:0] RSSI_RESET = -8'sd100;

	localparam int unsigned COUNT_WIDTH_DEF = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RSSI_NEAR   = 3'd0,
		REG_RSSI_FAR    = 3'd1,
		REG_SLOW_HALF   = 3'd2,
		REG_FAST_HALF   = 3'd3,
		REG_HOLD_TIME   = 3'd4,
		REG_IDLE_POLL   = 3'd5
	} cfg_reg_t;

	// Input action codes.
	localparam logic ACTION_TICK     = 1'b0;
	localparam logic ACTION_SIGHTING = 1'b1;

endpackage

// ===== sv/rpf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpf_if: valid/ready channels of the RSSI proximity flasher
// One channel carries ticks and sightings in, the other carries fill colors out.
// ----------------------------------------------------------------------------
interface rpf_item_if;
	logic              valid;
	logic              ready;
	logic              action;
	logic signed [7:0] rssi;

	modport source (output valid, output action, output rssi, input ready);
	modport sink   (input valid, input action, input rssi, output ready);
endinterface

interface rpf_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] fill_color;
	logic        alert_active;

	modport source (output valid, output fill_color, output alert_active, input ready);
	modport sink   (input valid, input fill_color, input alert_active, output ready);
endinterface

// ===== sv/rssi_proximity_flasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_proximity_flasher: proximity alert flasher driven by RSSI sightings
// Counts millisecond ticks, tracks the age of the last sighting and toggles
// the panel red/black at a rate set by the RSSI, or shows the idle color once.
//
//   channel  | dir | payload                      | transaction
//   ---------+-----+------------------------------+----------------------------
//   item     | in  | action, rssi                 | one tick or one sighting
//   result   | out | fill_color, alert_active     | one panel fill
//   cfg      | in  | cfg_we, cfg_index, cfg_data  | one register write
//
// A sighting, or a tick that does not expire the wait, is handled as it is
// accepted. A tick that shows the idle color goes straight to emit; one that
// flashes runs the multiply, the shift-subtract divider (which forms the
// quotient bit by bit), the reload step and emit. A flash whose span is not
// positive skips the divider and the reload step. Reset returns the control
// state and the registers to their defaults; the datapath words are not reset.
// The item channel is held off while a transaction is being worked on; a
// finished fill waits in the output register while the next item comes in.
// ----------------------------------------------------------------------------
module rssi_proximity_flasher #(
	parameter int unsigned COUNT_WIDTH = rpf_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	rpf_item_if.sink                        item,
	rpf_result_if.source                    result,
	input  logic                            cfg_we,
	input  logic [rpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rpf_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rpf_pkg::*;

	localparam int unsigned PROD_W = 24;
	localparam int unsigned CNT_W  = $clog2(PROD_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);
	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_DIV  = 5'b00100,
		S_FIN  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [15:0] v);
		logic [31:0] v32;
		v32 = {16'd0, v};
		if (v32 > COUNT_MAX)
			return COUNT_MAX[COUNT_WIDTH-1:0];
		else
			return v32[COUNT_WIDTH-1:0];
	endfunction

	// Configuration registers.
	logic signed [7:0] near_q, far_q;
	logic [15:0]       slow_q, fast_q, hold_q, idle_poll_q;

	// Block state.
	state_t                 state_q;
	logic                   seen_q;
	logic [AGE_W-1:0]       age_q;
	logic signed [7:0]      rssi_q;
	logic                   flash_q;
	logic                   idle_shown_q;
	logic [COUNT_WIDTH-1:0] wait_q;

	// Divider and pending result.
	logic [PROD_W-1:0] divd_q;
	logic [7:0]        rem_q;
	logic [7:0]        span_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sign_q;
	logic [15:0]       res_color_q;
	logic              res_alert_q;

	logic              out_valid_q;
	logic [15:0]       out_color_q;
	logic              out_alert_q;

	// Tick evaluation.
	logic                   accept;
	logic [AGE_W-1:0]       age_nxt;
	logic [COUNT_WIDTH-1:0] wait_dec;
	logic                   alert_now;

	// Half-period setup.
	logic signed [8:0]  span9;
	logic signed [7:0]  r_hi, r_cl;
	logic signed [8:0]  pos9;
	logic signed [16:0] diff17;
	logic [15:0]        abs_diff;
	logic [PROD_W-1:0]  prod;

	// Divider step and final reload.
	logic [8:0]  trial;
	logic        ge;
	logic [8:0]  trial_sub;
	logic [17:0] res18;
	logic        emit_go;

	assign item.ready   = (state_q == S_IDLE);
	assign accept       = item.valid && item.ready;
	assign result.valid        = out_valid_q;
	assign result.fill_color   = out_color_q;
	assign result.alert_active = out_alert_q;

	always_comb begin
		age_nxt   = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);
		wait_dec  = (wait_q != '0) ? wait_q - COUNT_WIDTH'(1) : wait_q;
		alert_now = seen_q && (age_nxt <= {1'b0, hold_q});

		span9    = {near_q[7], near_q} - {far_q[7], far_q};
		r_hi     = (rssi_q > near_q) ? near_q : rssi_q;
		r_cl     = (r_hi < far_q) ? far_q : r_hi;
		pos9     = {r_cl[7], r_cl} - {far_q[7], far_q};
		diff17   = $signed({1'b0, slow_q}) - $signed({1'b0, fast_q});
		abs_diff = diff17[16] ? 16'(-diff17) : diff17[15:0];
		prod     = PROD_W'(pos9[7:0]) * PROD_W'(abs_diff);

		trial     = {rem_q, divd_q[PROD_W-1]};
		ge        = (trial >= {1'b0, span_q});
		trial_sub = trial - {1'b0, span_q};

		// The quotient magnitude never exceeds |slow - fast|, so 16 bits hold it
		// and the reload always lands between the fast and slow periods.
		res18 = sign_q ? {2'b00, slow_q} + {2'b00, divd_q[15:0]}
		               : {2'b00, slow_q} - {2'b00, divd_q[15:0]};

		emit_go = (state_q == S_EMIT) && (!out_valid_q || result.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q      <= -8'sd50;
			far_q       <= -8'sd90;
			slow_q      <= 16'd500;
			fast_q      <= 16'd50;
			hold_q      <= 16'd3000;
			idle_poll_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RSSI_NEAR: near_q      <= cfg_data[7:0];
				REG_RSSI_FAR:  far_q       <= cfg_data[7:0];
				REG_SLOW_HALF: slow_q      <= cfg_data;
				REG_FAST_HALF: fast_q      <= cfg_data;
				REG_HOLD_TIME: hold_q      <= cfg_data;
				REG_IDLE_POLL: idle_poll_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			seen_q       <= 1'b0;
			age_q        <= '0;
			rssi_q       <= RSSI_RESET;
			flash_q      <= 1'b0;
			idle_shown_q <= 1'b0;
			wait_q       <= '0;
			cnt_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.action == ACTION_SIGHTING) begin
							rssi_q <= item.rssi;
							age_q  <= '0;
							seen_q <= 1'b1;
						end else begin
							age_q <= age_nxt;
							if (wait_dec != '0) begin
								wait_q <= wait_dec;
							end else if (alert_now) begin
								idle_shown_q <= 1'b0;
								flash_q      <= !flash_q;
								state_q      <= S_MUL;
							end else begin
								wait_q <= sat_count(idle_poll_q);
								if (!idle_shown_q) begin
									idle_shown_q <= 1'b1;
									flash_q      <= 1'b0;
									state_q      <= S_EMIT;
								end
							end
						end
					end
				end
				S_MUL: begin
					// A span that is not positive selects the fast period outright.
					if (span9[8] || span9 == 9'sd0) begin
						wait_q  <= sat_count(fast_q);
						state_q <= S_EMIT;
					end else begin
						cnt_q   <= LAST_STEP;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_FIN;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				S_FIN: begin
					wait_q  <= sat_count(res18[15:0]);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Divider datapath and pending result word.
	always_ff @(posedge clk) begin
		if (accept && item.action == ACTION_TICK) begin
			res_color_q <= alert_now ? (flash_q ? COLOR_BLACK : COLOR_RED) : COLOR_IDLE;
			res_alert_q <= alert_now;
		end
		if (state_q == S_MUL) begin
			span_q <= span9[7:0];
			divd_q <= prod;
			rem_q  <= '0;
			sign_q <= diff17[16];
		end else if (state_q == S_DIV) begin
			rem_q  <= ge ? trial_sub[7:0] : trial[7:0];
			divd_q <= {divd_q[PROD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_color_q <= res_color_q;
			out_alert_q <= res_alert_q;
		end
	end

`ifndef SYNTHESIS
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("output became valid without an emit step");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q != '0) |=>
			(state_q == S_DIV && cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("divider step count did not advance");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < span_q))
		else $error("divider remainder reached the divisor");

	a_alert_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_alert_q) |->
			(out_color_q == COLOR_RED || out_color_q == COLOR_BLACK))
		else $error("alert fill is neither red nor black");

	a_fin_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_EMIT))
		else $error("reload step not followed by emit");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the RSSI proximity flasher
// Drives ticks and sightings through the item channel with random bursts and
// gaps, stalls the result channel on changing patterns, and compares every
// panel fill with a behavioral model of the flasher kept in step with the
// accepted transactions. Covers reset defaults, interpolation, span and zero
// reload corners, register extremes, unused indexes, back pressure and the longest
// hold and poll values.
// ----------------------------------------------------------------------------
module tb;
	import rpf_pkg::*;

	localparam int CNT_W         = COUNT_WIDTH_DEF;
	localparam int WAIT_MAX      = (1 << CNT_W) - 1;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 20000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 80;

	// Indexes with no register behind them.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [15:0] color;
		logic        alert;
	} fill_t;

	typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PATTERN} rx_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpf_item_if   item_ch();
	rpf_result_if result_ch();

	rssi_proximity_flasher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Flasher model: registers and state.
	logic signed [7:0] cfg_near;
	logic signed [7:0] cfg_far;
	logic [15:0]       cfg_slow;
	logic [15:0]       cfg_fast;
	logic [15:0]       cfg_hold;
	logic [15:0]       cfg_poll;

	logic              fl_seen;
	logic [AGE_W-1:0]  fl_age;
	logic signed [7:0] fl_rssi;
	logic              fl_flash;
	logic              fl_idle_shown;
	logic [CNT_W-1:0]  fl_wait;

	fill_t expected_fills[$];

	int errors;
	int n_items;
	int n_sightings;
	int n_writes;
	int n_flash_fills;
	int n_idle_fills;
	int burst_left;
	bit gaps_on;
	int rx_hold_req;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Steps the model for one accepted transaction and queues the fill it causes.
	function automatic void predict_fill(logic act, logic signed [7:0] r);
		int nr;
		int fr;
		int rr;
		int span;
		int diff;
		int hp;
		if (act == ACTION_SIGHTING) begin
			fl_rssi = r;
			fl_age = '0;
			fl_seen = 1'b1;
			return;
		end
		if (fl_age != AGE_MAX)
			fl_age = fl_age + AGE_W'(1);
		if (fl_wait != 0)
			fl_wait = fl_wait - CNT_W'(1);
		if (fl_wait != 0)
			return;
		if (fl_seen && fl_age <= {1'b0, cfg_hold}) begin
			fl_idle_shown = 1'b0;
			fl_flash = !fl_flash;
			expected_fills.push_back('{fl_flash ? COLOR_RED : COLOR_BLACK, 1'b1});
			nr = cfg_near;
			fr = cfg_far;
			rr = fl_rssi;
			if (rr > nr)
				rr = nr;
			if (rr < fr)
				rr = fr;
			span = nr - fr;
			if (span <= 0) begin
				hp = int'(cfg_fast);
			end else begin
				diff = int'(cfg_slow) - int'(cfg_fast);
				hp = int'(cfg_slow) - ((rr - fr) * diff) / span;
			end
			fl_wait = (hp > WAIT_MAX) ? CNT_W'(WAIT_MAX) : hp[CNT_W-1:0];
			return;
		end
		fl_wait = CNT_W'(cfg_poll);
		if (!fl_idle_shown) begin
			fl_idle_shown = 1'b1;
			fl_flash = 1'b0;
			expected_fills.push_back('{COLOR_IDLE, 1'b0});
		end
	endfunction

	task automatic send_item(logic act, logic signed [7:0] r);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		item_ch.valid  <= 1'b1;
		item_ch.action <= act;
		item_ch.rssi   <= r;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
		n_items++;
		if (act == ACTION_SIGHTING)
			n_sightings++;
		predict_fill(act, r);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(ACTION_TICK, 8'($urandom));
	endtask

	// Ticks until the next tick is the one that evaluates.
	task automatic run_down_wait();
		while (fl_wait > 1)
			send_item(ACTION_TICK, 8'($urandom));
	endtask

	// Lets the block go idle: no item offered and every fill received.
	task automatic settle();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_fills.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		n_writes++;
		case (idx)
			REG_RSSI_NEAR: cfg_near = data[7:0];
			REG_RSSI_FAR:  cfg_far  = data[7:0];
			REG_SLOW_HALF: cfg_slow = data;
			REG_FAST_HALF: cfg_fast = data;
			REG_HOLD_TIME: cfg_hold = data;
			REG_IDLE_POLL: cfg_poll = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(logic signed [7:0] near, logic signed [7:0] far,
			logic [15:0] slow, logic [15:0] fast, logic [15:0] hold, logic [15:0] poll);
		logic [15:0] junk;
		junk = 16'($urandom);
		// The upper data bits of the RSSI registers carry noise that must be ignored.
		write_reg(REG_RSSI_NEAR, {junk[15:8], near});
		write_reg(REG_RSSI_FAR, {junk[7:0], far});
		write_reg(REG_SLOW_HALF, slow);
		write_reg(REG_FAST_HALF, fast);
		write_reg(REG_HOLD_TIME, hold);
		write_reg(REG_IDLE_POLL, poll);
		cfg_we <= 1'b0;
	endtask

	// Default registers: idle on the first tick, then flashing at the fast rate.
	task automatic test_reset_state();
		send_ticks(3);
		send_item(ACTION_SIGHTING, -8'sd50);
		send_ticks(200);
	endtask

	task automatic test_directed();
		logic signed [7:0] levels[5];
		levels = '{8'sd127, -8'sd128, 8'sd0, -8'sd1, -8'sd70};
		settle();
		program_regs(-8'sd50, -8'sd90, 16'd3, 16'd1, 16'd20, 16'd2);
		run_down_wait();
		foreach (levels[i]) begin
			send_item(ACTION_SIGHTING, levels[i]);
			send_ticks(3);
		end
	endtask

	task automatic test_span_and_zero_reload();
		settle();
		// Equal near and far: the fast period applies whatever the RSSI.
		program_regs(-8'sd60, -8'sd60, 16'hFFFF, 16'd3, 16'd100, 16'd2);
		run_down_wait();
		send_item(ACTION_SIGHTING, -8'sd60);
		send_ticks(12);
		settle();
		// Near below far gives a negative span.
		program_regs(-8'sd128, 8'sd127, 16'd9, 16'd2, 16'd100, 16'd2);
		send_item(ACTION_SIGHTING, 8'sd0);
		send_ticks(8);
		settle();
		// A zero reload evaluates again on the very next tick.
		program_regs(-8'sd40, -8'sd80, 16'd0, 16'd0, 16'd1, 16'd0);
		run_down_wait();
		send_item(ACTION_SIGHTING, -8'sd60);
		send_ticks(5);
		send_item(ACTION_SIGHTING, -8'sd60);
		send_ticks(4);
	endtask

	task automatic test_register_extremes();
		settle();
		// Slow shorter than fast: the interpolation runs with a negative slope.
		program_regs(8'sd127, -8'sd128, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
		run_down_wait();
		send_item(ACTION_SIGHTING, -8'sd128);
		send_ticks(4);
		send_item(ACTION_SIGHTING, -8'sd127);
		send_ticks(600);
	endtask

	task automatic test_unknown_index();
		settle();
		program_regs(-8'sd30, -8'sd100, 16'd6, 16'd2, 16'd40, 16'd3);
		write_reg(REG_SPARE_6, 16'h0000);
		write_reg(REG_SPARE_7, 16'hFFFF);
		cfg_we <= 1'b0;
		run_down_wait();
		send_item(ACTION_SIGHTING, -8'sd65);
		send_ticks(60);
	endtask

	task automatic test_back_pressure();
		settle();
		program_regs(-8'sd50, -8'sd90, 16'd2, 16'd1, 16'd400, 16'd1);
		run_down_wait();
		rx_hold_req = 1000;
		send_item(ACTION_SIGHTING, -8'sd45);
		send_ticks(300);
	endtask

	task automatic test_random();
		logic signed [7:0] near;
		logic signed [7:0] far;
		logic [15:0] slow;
		logic [15:0] fast;
		logic [15:0] hold;
		logic [15:0] poll;
		int budget;
		int run;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			gaps_on = (phase % 3 != 2);
			near = 8'($urandom);
			far  = ($urandom_range(0, 4) == 0) ? near : 8'($urandom);
			slow = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
			fast = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
			hold = 16'($urandom_range(0, 80));
			poll = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
			program_regs(near, far, slow, fast, hold, poll);
			budget = PHASE_ITEMS;
			while (budget > 0) begin
				if ($urandom_range(0, 9) < 8) begin
					// A sighting followed by a run of ticks that can outlast the hold time.
					send_item(ACTION_SIGHTING, 8'($urandom));
					run = $urandom_range(1, int'(cfg_hold) + 30);
					if (run > budget)
						run = budget;
					send_ticks(run);
					budget -= run + 1;
				end else begin
					run = $urandom_range(1, 8);
					repeat (run) send_item(1'($urandom), 8'($urandom));
					budget -= run;
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	// The longest hold keeps flashing going; a zero hold never flashes and the
	// idle color then stands for the longest poll.
	task automatic test_long_registers();
		settle();
		program_regs(-8'sd50, -8'sd90, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
		run_down_wait();
		send_item(ACTION_SIGHTING, 8'($urandom));
		send_ticks(40);
		settle();
		program_regs(-8'sd50, -8'sd90, 16'd1, 16'd1, 16'd0, 16'hFFFF);
		send_item(ACTION_SIGHTING, 8'($urandom));
		send_ticks(20);
	endtask

	initial begin
		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.action  <= ACTION_TICK;
		item_ch.rssi    <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_RSSI_NEAR;
		cfg_data        <= '0;
		cfg_near        = -8'sd50;
		cfg_far         = -8'sd90;
		cfg_slow        = 16'd500;
		cfg_fast        = 16'd50;
		cfg_hold        = 16'd3000;
		cfg_poll        = 16'd100;
		fl_seen         = 1'b0;
		fl_age          = '0;
		fl_rssi         = RSSI_RESET;
		fl_flash        = 1'b0;
		fl_idle_shown   = 1'b0;
		fl_wait         = '0;
		errors          = 0;
		n_items         = 0;
		n_sightings     = 0;
		n_writes        = 0;
		burst_left      = 0;
		gaps_on         = 1'b1;
		rx_hold_req     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed();
		test_span_and_zero_reload();
		test_register_extremes();
		test_unknown_index();
		test_back_pressure();
		test_random();
		test_long_registers();

		settle();
		$display("Run covered %0d transactions (%0d sightings) and %0d register writes.",
			n_items, n_sightings, n_writes);
		$display("Checked %0d flash fills and %0d idle fills; %0d mismatches.",
			n_flash_fills, n_idle_fills, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: changing stall patterns, plus a long hold-off on request.
	initial begin : result_stall
		rx_mode_t mode;
		int mode_left;
		int hold_left;
		int beat;
		mode      = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		beat      = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(50, 400);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_ALWAYS:  result_ch.ready <= 1'b1;
					RX_HALF:    result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:  result_ch.ready <= ($urandom_range(0, 3) == 0);
					RX_PATTERN: result_ch.ready <= ((beat % 8) >= 3);
					default:    result_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_fill
		fill_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (result_ch.alert_active)
				n_flash_fills++;
			else
				n_idle_fills++;
			if (expected_fills.size() == 0) begin
				$display("%0t: unexpected fill color %h alert %b, none expected",
					$time, result_ch.fill_color, result_ch.alert_active);
				errors++;
			end else begin
				want = expected_fills.pop_front();
				if (result_ch.fill_color !== want.color) begin
					$display("%0t: fill_color expected %h, actual %h",
						$time, want.color, result_ch.fill_color);
					errors++;
				end
				if (result_ch.alert_active !== want.alert) begin
					$display("%0t: alert_active expected %b, actual %b",
						$time, want.alert, result_ch.alert_active);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction completes for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d fills outstanding",
					$time, idle_cycles, expected_fills.size());
				$display("TEST FAILED");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule

// ===== rssi_proximity_flasher.f =====
sv/rpf_pkg.sv
sv/rpf_if.sv
sv/rssi_proximity_flasher.sv
verif/tb.sv
